@@ src/nsd_pkg.sv @@
// Shared types and constants for the netstring deframer.
// Used by nsd_step and netstring_deframer_core; no dependencies.
package nsd_pkg;

  // Most length digits accepted before a too-long error
  localparam int unsigned MAX_DIGITS = 9;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LIMIT_W  = 32;
  localparam int unsigned LEN_W    = 30;
  localparam int unsigned OFFSET_W = 4;
  localparam int unsigned IDX_W    = 4;

  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_DIGITS  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_COMMA   = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    K_DATA = 2'd0,
    K_OK   = 2'd1,
    K_FAIL = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_LONG     = 3'd1,
    ST_NO_COLON     = 3'd2,
    ST_TOO_SHORT    = 3'd3,
    ST_NO_COMMA     = 3'd4,
    ST_LEADING_ZERO = 3'd5,
    ST_NO_LENGTH    = 3'd6
  } status_t;

  // Parser state; idx counts the length digits seen so far
  typedef struct packed {
    phase_t              phase;
    logic [IDX_W-1:0]    idx;
    logic [LEN_W-1:0]    acc;
    logic [LIMIT_W-1:0]  limit;
    logic [LEN_W-1:0]    remaining;
    logic                first_zero;
  } nsd_state_t;

  typedef struct packed {
    logic                valid;
    kind_t               kind;
    logic [BYTE_W-1:0]   payload_byte;
    status_t             status;
    logic [LEN_W-1:0]    payload_length;
    logic [OFFSET_W-1:0] payload_offset;
  } nsd_result_t;

endpackage

@@ src/nsd_step.sv @@
// Next-state and result logic of the deframer for one byte.
// Depends on nsd_pkg.
module nsd_step
  import nsd_pkg::*;
(
  input  nsd_state_t          state_i,
  input  logic [BYTE_W-1:0]   data_byte_i,
  input  logic                first_i,
  input  logic [LIMIT_W-1:0]  total_length_i,
  output nsd_state_t          state_o,
  output nsd_result_t         result_o
);

  logic              is_dec;
  logic [BYTE_W-1:0] digit;
  logic [33:0]       acc_wide;
  logic [LIMIT_W:0]  idx_plus1;
  logic [LIMIT_W:0]  frame_end;
  logic [LIMIT_W:0]  limit_ext;

  assign is_dec    = (data_byte_i >= CHAR_ZERO) && (data_byte_i <= CHAR_NINE);
  assign digit     = data_byte_i - CHAR_ZERO;
  // acc * 10 + digit as two shifts and adds
  assign acc_wide  = {1'b0, state_i.acc, 3'b000} + {3'b000, state_i.acc, 1'b0}
                   + {26'd0, digit};
  assign idx_plus1 = {{(LIMIT_W+1-IDX_W){1'b0}}, state_i.idx} + 33'd1;
  assign frame_end = idx_plus1 + {3'b000, state_i.acc};
  assign limit_ext = {1'b0, state_i.limit};

  always_comb begin
    state_o  = state_i;
    result_o = '{valid: 1'b0, kind: K_DATA, payload_byte: '0, status: ST_OK,
                 payload_length: '0, payload_offset: '0};

    if (first_i) begin
      // Restart on a marked first byte
      state_o.phase      = PH_DIGITS;
      state_o.idx        = IDX_W'(1);
      state_o.acc        = {{(LEN_W-BYTE_W){1'b0}}, digit};
      state_o.limit      = total_length_i;
      state_o.remaining  = '0;
      state_o.first_zero = (data_byte_i == CHAR_ZERO);
      if (total_length_i < 32'd3) begin
        state_o.phase   = PH_DONE;
        state_o.idx     = '0;
        state_o.acc     = '0;
        state_o.first_zero = 1'b0;
        result_o.valid  = 1'b1;
        result_o.kind   = K_FAIL;
        result_o.status = ST_TOO_SHORT;
      end else if (!is_dec) begin
        state_o.phase   = PH_DONE;
        state_o.idx     = '0;
        state_o.acc     = '0;
        state_o.first_zero = 1'b0;
        result_o.valid  = 1'b1;
        result_o.kind   = K_FAIL;
        result_o.status = ST_NO_LENGTH;
      end
    end else begin
      case (state_i.phase)
        PH_DIGITS: begin
          result_o.kind = K_FAIL;
          if (is_dec) begin
            // Another length digit
            if (state_i.first_zero && (state_i.idx == IDX_W'(1))) begin
              state_o.phase   = PH_DONE;
              result_o.valid  = 1'b1;
              result_o.status = ST_LEADING_ZERO;
            end else if (state_i.idx >= IDX_W'(MAX_DIGITS)) begin
              state_o.phase   = PH_DONE;
              result_o.valid  = 1'b1;
              result_o.status = ST_TOO_LONG;
            end else begin
              state_o.acc = acc_wide[LEN_W-1:0];
              if (idx_plus1 >= limit_ext) begin
                state_o.phase   = PH_DONE;
                result_o.valid  = 1'b1;
                result_o.status = ST_TOO_SHORT;
              end else begin
                state_o.idx = state_i.idx + IDX_W'(1);
              end
            end
          end else if (frame_end >= limit_ext) begin
            state_o.phase   = PH_DONE;
            result_o.valid  = 1'b1;
            result_o.status = ST_TOO_SHORT;
          end else if (data_byte_i != CHAR_COLON) begin
            state_o.phase   = PH_DONE;
            result_o.valid  = 1'b1;
            result_o.status = ST_NO_COLON;
          end else begin
            // Colon found: payload follows
            state_o.remaining = state_i.acc;
            state_o.phase     = (state_i.acc != '0) ? PH_PAYLOAD : PH_COMMA;
          end
        end
        PH_PAYLOAD: begin
          // Pass the byte through
          state_o.remaining     = state_i.remaining - LEN_W'(1);
          if (state_i.remaining == LEN_W'(1)) begin
            state_o.phase = PH_COMMA;
          end
          result_o.valid        = 1'b1;
          result_o.kind         = K_DATA;
          result_o.payload_byte = data_byte_i;
        end
        PH_COMMA: begin
          state_o.phase  = PH_DONE;
          result_o.valid = 1'b1;
          if (data_byte_i != CHAR_COMMA) begin
            result_o.kind   = K_FAIL;
            result_o.status = ST_NO_COMMA;
          end else begin
            result_o.kind           = K_OK;
            result_o.payload_length = state_i.acc;
            result_o.payload_offset = state_i.idx + OFFSET_W'(1);
          end
        end
        default: begin
          // Idle or finished: drop the byte
        end
      endcase
    end
  end

endmodule

@@ src/netstring_deframer_core.sv @@
// Top level of the netstring deframer: input register, state register, result register.
// Depends on nsd_pkg and nsd_step.

// The block parses one netstring ("<length>:<payload>,") from a byte stream, one byte
// per item and one item per cycle sustained unless the result channel stalls. A byte
// marked by in_tuser starts a new buffer and carries the buffer length. Payload bytes
// come out with kind 0, and the parse ends with one ok item (length and offset) or one
// error item; later bytes are dropped until the next first byte. An item's result is
// held in the input register and then the result register before it is presented on
// the result channel; the parser's next state is computed combinationally between the
// input register and the result register, so a new byte can follow each accepted one.
module netstring_deframer_core
  import nsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // data_byte [7:0], total_length [39:8]
  input  logic        in_tuser,   // first
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // payload_byte [7:0], status [10:8],
                                  // payload_length [40:11], payload_offset [44:41],
                                  // zero [47:45]
  output logic [1:0]  out_tuser   // kind
);

  logic                s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0]   s1_byte_r;
  logic                s1_first_r;
  logic [LIMIT_W-1:0]  s1_len_r;
  logic                s1_adv;
  nsd_state_t          state_r, state_nxt;
  nsd_result_t         result;
  logic                out_valid_r, out_valid_nxt;
  nsd_result_t         out_r;

  // Move the held item on when the result register is free or draining
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  nsd_step u_step (
    .state_i        (state_r),
    .data_byte_i    (s1_byte_r),
    .first_i        (s1_first_r),
    .total_length_i (s1_len_r),
    .state_o        (state_nxt),
    .result_o       (result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv && result.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{phase: PH_IDLE, idx: '0, acc: '0, limit: '0,
                       remaining: '0, first_zero: 1'b0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r  <= in_tdata[7:0];
      s1_len_r   <= in_tdata[39:8];
      s1_first_r <= in_tuser;
    end
    if (s1_adv && result.valid) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {3'b000, out_r.payload_offset, out_r.payload_length,
                       out_r.status, out_r.payload_byte};

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for netstring_deframer_core: directed buffers, then random frames.
// Depends on nsd_pkg and the deframer RTL; a built-in parser predicts every result item.
module testbench;
  import nsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MIN_BUFFER   = 3;
  localparam int unsigned DECIMAL_BASE = 10;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Expected result item, holding the same fields as the result channel
  typedef struct packed {
    kind_t                kind;
    logic [BYTE_W-1:0]    pbyte;
    status_t              status;
    logic [LEN_W-1:0]     plen;
    logic [OFFSET_W-1:0]  poff;
    logic [2:0]           pad;
  } frame_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // data_byte [7:0], total_length [39:8]
  logic        in_tuser;   // first
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // payload_byte [7:0], status [10:8], payload_length [40:11],
                           // payload_offset [44:41], zero [47:45]
  logic [1:0]  out_tuser;  // kind

  netstring_deframer_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Parser state mirrored by the predictor
  phase_t             ps_phase;
  logic [31:0]        ps_index;
  logic [LEN_W-1:0]   ps_acc;
  logic [LIMIT_W-1:0] ps_limit;
  logic [LEN_W-1:0]   ps_remaining;
  logic               ps_zero;

  frame_result_t expected_q[$];
  bit            idle_en;
  bit            stall_en;
  int unsigned   items_sent;
  int unsigned   buffers_seen;
  int unsigned   results_checked;
  int unsigned   payload_count;
  int unsigned   ok_count;
  int unsigned   status_count[7];
  int unsigned   mismatches;
  int unsigned   quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // End the parse with an error item
  function automatic bit parse_fail(input status_t st, output frame_result_t r);
    r = '0;
    r.kind = K_FAIL;
    r.status = st;
    ps_phase = PH_DONE;
    return 1'b1;
  endfunction

  // Advance the parser by one byte; return 1 when the byte yields a result item
  function automatic bit parse_byte(input logic [7:0] b, input logic is_first,
                                    input logic [31:0] tlen, output frame_result_t r);
    logic        digit;
    logic [33:0] span;
    r = '0;
    digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    if (is_first) begin
      ps_phase = PH_IDLE;
      ps_index = '0;
      ps_acc = '0;
      ps_remaining = '0;
      ps_zero = 1'b0;
      ps_limit = tlen;
      if (tlen < MIN_BUFFER) return parse_fail(ST_TOO_SHORT, r);
      if (!digit) return parse_fail(ST_NO_LENGTH, r);
      ps_zero = (b == CHAR_ZERO);
      ps_acc = 30'(b - CHAR_ZERO);
      ps_index = 32'd1;
      ps_phase = PH_DIGITS;
      return 1'b0;
    end
    case (ps_phase)
      PH_DIGITS: begin
        if (digit) begin
          if (ps_zero && ps_index == 32'd1) return parse_fail(ST_LEADING_ZERO, r);
          if (ps_index >= MAX_DIGITS) return parse_fail(ST_TOO_LONG, r);
          ps_acc = 30'(ps_acc * DECIMAL_BASE + (b - CHAR_ZERO));
          if (34'(ps_index) + 34'd1 >= 34'(ps_limit)) return parse_fail(ST_TOO_SHORT, r);
          ps_index = ps_index + 32'd1;
          return 1'b0;
        end
        // length plus colon and comma must fit in the buffer
        span = 34'(ps_index) + 34'(ps_acc) + 34'd1;
        if (span >= 34'(ps_limit)) return parse_fail(ST_TOO_SHORT, r);
        if (b != CHAR_COLON) return parse_fail(ST_NO_COLON, r);
        ps_index = ps_index + 32'd1;
        ps_remaining = ps_acc;
        ps_phase = (ps_remaining != '0) ? PH_PAYLOAD : PH_COMMA;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        ps_index = ps_index + 32'd1;
        ps_remaining = ps_remaining - 30'd1;
        if (ps_remaining == '0) ps_phase = PH_COMMA;
        r.kind = K_DATA;
        r.pbyte = b;
        return 1'b1;
      end
      PH_COMMA: begin
        if (b != CHAR_COMMA) return parse_fail(ST_NO_COMMA, r);
        ps_phase = PH_DONE;
        r.kind = K_OK;
        r.plen = ps_acc;
        r.poff = 4'(ps_index - 32'(ps_acc));
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Predict on every accepted input item, check every accepted result item, watch for hangs
  always @(posedge clk) begin : monitor
    frame_result_t pred;
    frame_result_t got;
    frame_result_t want;
    bit            moved;
    moved = 1'b0;
    if (rst_n && in_tvalid && in_tready) begin
      moved = 1'b1;
      if (in_tuser) buffers_seen++;
      if (parse_byte(in_tdata[7:0], in_tuser, in_tdata[39:8], pred)) expected_q.push_back(pred);
    end
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      moved = 1'b1;
      got.kind = kind_t'(out_tuser);
      got.pbyte = out_tdata[7:0];
      got.status = status_t'(out_tdata[10:8]);
      got.plen = out_tdata[40:11];
      got.poff = out_tdata[44:41];
      got.pad = out_tdata[47:45];
      if (expected_q.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected result: kind %0d byte %02h status %0d len %0d off %0d",
                   got.kind, got.pbyte, got.status, got.plen, got.poff);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        case (want.kind)
          K_DATA:  payload_count++;
          K_OK:    ok_count++;
          default: status_count[want.status]++;
        endcase
        if (got !== want) begin
          if (mismatches < REPORT_LIMIT)
            $display("mismatch: expected kind %0d byte %02h status %0d len %0d off %0d pad %0d,%s",
                     want.kind, want.pbyte, want.status, want.plen, want.poff, want.pad,
                     $sformatf(" got kind %0d byte %02h status %0d len %0d off %0d pad %0d",
                               got.kind, got.pbyte, got.status, got.plen, got.poff, got.pad));
          mismatches++;
        end
      end
    end
    // Bail out when neither channel moves for too long
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_q.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Stall the result channel in random bursts
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_en && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Present one input item, with an optional idle burst ahead of it, and hold until taken
  task automatic send_byte(input logic [7:0] b, input logic is_first, input logic [31:0] tlen);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {tlen, b};
    in_tuser <= is_first;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    items_sent++;
  endtask

  // Send a text buffer, marking its first byte
  task automatic send_text(input string s, input logic [31:0] tlen);
    for (int k = 0; k < s.len(); k++) send_byte(s[k], k == 0, tlen);
  endtask

  // Build one netstring with random content, sometimes damaged, and send it
  task automatic send_random_frame;
    int unsigned  len_val;
    int unsigned  flaw;
    int unsigned  pick;
    int unsigned  cut;
    int unsigned  colon_at;
    bit           huge;
    string        hdr;
    logic [7:0]   frame[$];
    logic [31:0]  tlen;
    flaw = $urandom_range(0, 99);
    huge = ($urandom_range(0, 19) == 0);
    if (huge) len_val = $urandom_range(1000, 999999999);
    else if ($urandom_range(0, 4) == 0) len_val = $urandom_range(13, 60);
    else len_val = $urandom_range(0, 12);
    hdr = $sformatf("%0d", len_val);
    if (flaw >= 70 && flaw < 75) hdr = {"0", hdr};
    else if (flaw >= 75 && flaw < 80) repeat ($urandom_range(7, 10)) hdr = {"9", hdr};
    for (int k = 0; k < hdr.len(); k++) frame.push_back(hdr[k]);
    colon_at = hdr.len();
    frame.push_back(CHAR_COLON);
    // a huge length cannot be carried through; cut the payload short
    if (huge) begin
      repeat ($urandom_range(0, 6)) frame.push_back(8'($urandom));
    end else begin
      repeat (len_val) frame.push_back(8'($urandom));
      frame.push_back(CHAR_COMMA);
    end
    if (flaw >= 80 && flaw < 85) frame[colon_at] = 8'($urandom);
    else if (flaw >= 85 && flaw < 90) frame[frame.size() - 1] = 8'($urandom);
    else if (flaw >= 90 && flaw < 95) frame[0] = 8'($urandom);
    else if (flaw >= 95) begin
      cut = $urandom_range(1, frame.size());
      while (frame.size() > cut) void'(frame.pop_back());
    end
    // buffer length: mostly exact, else roomy, too small or anything at all
    pick = $urandom_range(0, 99);
    if (huge) tlen = $urandom | 32'h8000_0000;
    else if (pick < 60) tlen = frame.size();
    else if (pick < 75) tlen = frame.size() + $urandom_range(1, 5);
    else if (pick < 90) tlen = $urandom_range(0, frame.size() - 1);
    else tlen = $urandom;
    foreach (frame[k]) send_byte(frame[k], k == 0, k == 0 ? tlen : $urandom);
    // trailing bytes after the parse are dropped by the block
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, $urandom);
  endtask

  // Extremes of the fields, every status and each special case
  task automatic test_directed;
    send_byte(8'h41, 1'b0, 32'd0);           // stray byte while idle
    send_byte(8'h35, 1'b1, 32'd2);           // buffer too short, digit first
    send_byte(8'hFF, 1'b1, 32'd0);           // buffer too short, empty length
    send_byte(8'h00, 1'b1, 32'hFFFF_FFFF);   // no digit first
    send_byte(CHAR_COLON, 1'b0, 32'd0);      // stray byte after a result
    send_text("01", 32'd10);                 // leading zero
    send_text("0:,", 32'd3);                 // empty payload in the smallest buffer
    send_text("3x", 32'd10);                 // colon missing
    send_text("5:", 32'd6);                  // length does not fit the buffer
    send_text("123", 32'd3);                 // digits fill the buffer
    send_text("1:", 32'd4);                  // comma missing
    send_byte(8'hFF, 1'b0, 32'd0);
    send_byte(8'h3B, 1'b0, 32'd0);
    send_text("7", 32'd100);                 // abandoned by the restart below
    send_text("9999999999", 32'hFFFF_FFFF);  // one digit too many
  endtask

  // Random frames with idling and stalls on both channels
  task automatic test_random_frames(input int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    idle_en = 1'b1;
    stall_en = 1'b1;
    while (items_sent < stop_at) send_random_frame();
  endtask

  // Random frames back to back at full rate
  task automatic test_full_rate(input int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    idle_en = 1'b0;
    stall_en = 1'b0;
    while (items_sent < stop_at) send_random_frame();
  endtask

  // Drain outstanding results, summarise and give the verdict
  task automatic finish_run;
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d input items in %0d buffers: %0d payload bytes, %0d ok frames",
             items_sent, buffers_seen, payload_count, ok_count);
    $display("errors seen: too long %0d, no colon %0d, too short %0d, no comma %0d, %s",
             status_count[ST_TOO_LONG], status_count[ST_NO_COLON],
             status_count[ST_TOO_SHORT], status_count[ST_NO_COMMA],
             $sformatf("leading zero %0d, no length %0d; %0d mismatches",
                       status_count[ST_LEADING_ZERO], status_count[ST_NO_LENGTH], mismatches));
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    idle_en = 1'b0;
    stall_en = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_frames(550);
    test_full_rate(150);
    finish_run();
  end

endmodule
